/* hw/rtl/orlc_pkg.sv */
// Shared constants, types and helper functions for the color reply classifier.
`default_nettype none
package orlc_pkg;

	localparam int MAX_HEX_DIGITS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF    = 4;

	localparam int COUNT_W_MAX = 3;
	localparam int ACC_W_MAX   = 16;
	localparam int SCALE_K_W   = 29;
	localparam int SCALE_P_W   = ACC_W_MAX + SCALE_K_W;
	localparam int LUMA_W      = 22;

	localparam logic [1:0] OUTCOME_NONE  = 2'd0;
	localparam logic [1:0] OUTCOME_DARK  = 2'd1;
	localparam logic [1:0] OUTCOME_LIGHT = 2'd2;

	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] PREFIX_TEXT [4] = '{8'h72, 8'h67, 8'h62, 8'h3A};

	localparam logic [LUMA_W-1:0] LUMA_WEIGHT [3] = '{22'd2126, 22'd7152, 22'd722};
	localparam logic [LUMA_W-1:0] DARK_LIMIT = 22'd1280000;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] ch);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			h.value = 4'(ch - 8'h30);
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			h.value = 4'(ch - 8'h57);
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			h.value = 4'(ch - 8'h37);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

	// Reciprocal multipliers for v*255/(16^n-1); exact over the full digit range.
	function automatic logic [SCALE_K_W-1:0] scale_mult(input logic [COUNT_W_MAX-1:0] count);
		logic [SCALE_K_W-1:0] k;
		case (count)
			3'd1:    k = 29'd17;
			3'd2:    k = 29'd1;
			3'd3:    k = 29'd267452177;
			3'd4:    k = 29'd65281;
			default: k = 29'd0;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] scale_pick(input logic [SCALE_P_W-1:0] prod,
			input logic [COUNT_W_MAX-1:0] count);
		logic [7:0] level;
		case (count)
			3'd1, 3'd2: level = prod[7:0];
			3'd3:       level = prod[39:32];
			3'd4:       level = prod[31:24];
			default:    level = 8'd0;
		endcase
		return level;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/orlc_parser.sv */
// Front end: byte parser that finds "rgb:" and collects the three hex channels.
`default_nettype none
module orlc_parser
	import orlc_pkg::*;
#(
	parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF,
	parameter int ENTRY_W = 3 * ($clog2(MAX_HEX_DIGITS + 1) + 4 * MAX_HEX_DIGITS) + 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         reply_byte,
	input  wire logic               end_of_reply,
	input  wire logic               queue_full,
	output logic                    push,
	output logic [ENTRY_W-1:0]      push_entry
);

	localparam int CNT_W = $clog2(MAX_HEX_DIGITS + 1);
	localparam int ACC_W = 4 * MAX_HEX_DIGITS;

	typedef enum logic [5:0] {
		PH_SEARCH = 6'b000001,
		PH_RED    = 6'b000010,
		PH_GREEN  = 6'b000100,
		PH_BLUE   = 6'b001000,
		PH_DONE   = 6'b010000,
		PH_FAIL   = 6'b100000
	} phase_t;

	phase_t             phase_q, phase_n, fin_phase;
	logic [1:0]         prefix_q, prefix_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic [ACC_W-1:0]   acc_q, acc_n;
	logic [ACC_W-1:0]   red_acc_q, red_acc_n, green_acc_q, green_acc_n;
	logic [ACC_W-1:0]   blue_acc_q, blue_acc_n, fin_blue_acc;
	logic [CNT_W-1:0]   red_cnt_q, red_cnt_n, green_cnt_q, green_cnt_n;
	logic [CNT_W-1:0]   blue_cnt_q, blue_cnt_n, fin_blue_cnt;
	hex_t               hx;
	logic               accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && end_of_reply;

	always_comb begin
		phase_n     = phase_q;
		prefix_n    = prefix_q;
		cnt_n       = cnt_q;
		acc_n       = acc_q;
		red_acc_n   = red_acc_q;
		red_cnt_n   = red_cnt_q;
		green_acc_n = green_acc_q;
		green_cnt_n = green_cnt_q;
		blue_acc_n  = blue_acc_q;
		blue_cnt_n  = blue_cnt_q;
		hx          = hex_digit(reply_byte);
		case (phase_q)
			PH_SEARCH: begin
				if (reply_byte == PREFIX_TEXT[prefix_q]) begin
					if (prefix_q == 2'd3) begin
						phase_n  = PH_RED;
						prefix_n = 2'd0;
						cnt_n    = '0;
						acc_n    = '0;
					end else begin
						prefix_n = prefix_q + 2'd1;
					end
				end else begin
					// restart the match, a stray 'r' counts as its first character
					prefix_n = (reply_byte == CH_R) ? 2'd1 : 2'd0;
				end
			end
			PH_RED, PH_GREEN, PH_BLUE: begin
				if (hx.valid && cnt_q < CNT_W'(MAX_HEX_DIGITS)) begin
					acc_n = ACC_W'({acc_q, hx.value});
					cnt_n = cnt_q + CNT_W'(1);
				end else if (cnt_q == '0) begin
					phase_n = PH_FAIL;
				end else begin
					acc_n = '0;
					cnt_n = '0;
					case (phase_q)
						PH_RED: begin
							red_acc_n = acc_q;
							red_cnt_n = cnt_q;
							phase_n   = (reply_byte == CH_SLASH) ? PH_GREEN : PH_FAIL;
						end
						PH_GREEN: begin
							green_acc_n = acc_q;
							green_cnt_n = cnt_q;
							phase_n     = (reply_byte == CH_SLASH) ? PH_BLUE : PH_FAIL;
						end
						default: begin
							blue_acc_n = acc_q;
							blue_cnt_n = cnt_q;
							phase_n    = PH_DONE;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// A reply that ends inside blue with digits in hand still completes blue.
	always_comb begin
		fin_phase    = phase_n;
		fin_blue_acc = blue_acc_n;
		fin_blue_cnt = blue_cnt_n;
		if (phase_n == PH_BLUE && cnt_n != '0) begin
			fin_phase    = PH_DONE;
			fin_blue_acc = acc_n;
			fin_blue_cnt = cnt_n;
		end
	end

	assign push_entry = {fin_phase == PH_DONE,
		fin_blue_cnt, fin_blue_acc,
		green_cnt_n, green_acc_n,
		red_cnt_n, red_acc_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			prefix_q <= 2'd0;
			cnt_q    <= '0;
			acc_q    <= '0;
		end else if (accept) begin
			if (end_of_reply) begin
				phase_q  <= PH_SEARCH;
				prefix_q <= 2'd0;
				cnt_q    <= '0;
				acc_q    <= '0;
			end else begin
				phase_q  <= phase_n;
				prefix_q <= prefix_n;
				cnt_q    <= cnt_n;
				acc_q    <= acc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_acc_q   <= red_acc_n;
			red_cnt_q   <= red_cnt_n;
			green_acc_q <= green_acc_n;
			green_cnt_q <= green_cnt_n;
			blue_acc_q  <= blue_acc_n;
			blue_cnt_q  <= blue_cnt_n;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/orlc_queue.sv */
// Short register queue between the parser and the rescale pipeline.
`default_nettype none
module orlc_queue
	import orlc_pkg::*;
#(
	parameter int WIDTH = 1,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + CNT_W'($past(push)) - CNT_W'($past(pop)))
		else $error("queue fill count out of step with transfers");

endmodule
`default_nettype wire

/* hw/rtl/orlc_scaler.sv */
// Back end: channel rescale, luma weighting, the dark/light compare and the output register.
`default_nettype none
module orlc_scaler
	import orlc_pkg::*;
#(
	parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF,
	parameter int ENTRY_W = 3 * ($clog2(MAX_HEX_DIGITS + 1) + 4 * MAX_HEX_DIGITS) + 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire logic [ENTRY_W-1:0] q_data,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              outcome,
	output logic [7:0]              red_level,
	output logic [7:0]              green_level,
	output logic [7:0]              blue_level
);

	localparam int CNT_W  = $clog2(MAX_HEX_DIGITS + 1);
	localparam int ACC_W  = 4 * MAX_HEX_DIGITS;
	localparam int LANE_W = CNT_W + ACC_W;

	logic                   advance;
	logic                   v_s1, v_s2, v_s3;
	logic                   ok_s1, ok_s2, ok_s3;
	logic [SCALE_P_W-1:0]   prod_s1 [3];
	logic [COUNT_W_MAX-1:0] cnt_s1 [3];
	logic [7:0]             level_s2 [3];
	logic [7:0]             level_s3 [3];
	logic [LUMA_W-1:0]      wt_s3 [3];
	logic [LUMA_W-1:0]      luma;
	logic                   out_valid_q;
	logic [1:0]             outcome_q;
	logic [7:0]             red_q, green_q, blue_q;

	// Whole pipeline holds while a result waits at the output.
	assign advance = !out_valid_q || out_ready;
	assign q_pop   = advance && !q_empty;
	assign luma    = wt_s3[0] + wt_s3[1] + wt_s3[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_s1 <= q_data[3*LANE_W];
			ok_s2 <= ok_s1;
			ok_s3 <= ok_s2;
			for (int c = 0; c < 3; c++) begin
				cnt_s1[c]   <= COUNT_W_MAX'(q_data[c*LANE_W+ACC_W +: CNT_W]);
				prod_s1[c]  <= SCALE_P_W'(q_data[c*LANE_W +: ACC_W])
					* SCALE_P_W'(scale_mult(COUNT_W_MAX'(q_data[c*LANE_W+ACC_W +: CNT_W])));
				level_s2[c] <= ok_s1 ? scale_pick(prod_s1[c], cnt_s1[c]) : 8'd0;
				level_s3[c] <= level_s2[c];
				wt_s3[c]    <= LUMA_W'(level_s2[c]) * LUMA_WEIGHT[c];
			end
			if (!ok_s3) begin
				outcome_q <= OUTCOME_NONE;
			end else if (luma < DARK_LIMIT) begin
				outcome_q <= OUTCOME_DARK;
			end else begin
				outcome_q <= OUTCOME_LIGHT;
			end
			red_q   <= level_s3[0];
			green_q <= level_s3[1];
			blue_q  <= level_s3[2];
		end
	end

	assign out_valid   = out_valid_q;
	assign outcome     = outcome_q;
	assign red_level   = red_q;
	assign green_level = green_q;
	assign blue_level  = blue_q;

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && outcome_q == OUTCOME_NONE |->
			red_q == 8'd0 && green_q == 8'd0 && blue_q == 8'd0)
		else $error("malformed reply carries nonzero levels");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |->
			outcome_q == OUTCOME_NONE || outcome_q == OUTCOME_DARK
			|| outcome_q == OUTCOME_LIGHT)
		else $error("undefined outcome code");

	a_ok_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ok_s1 |->
			cnt_s1[0] != '0 && cnt_s1[1] != '0 && cnt_s1[2] != '0)
		else $error("complete reply with an empty channel");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !advance |=> v_s3)
		else $error("stalled stage dropped an item");

endmodule
`default_nettype wire

/* hw/rtl/osc_rgb_reply_luma_classifier.sv */
// Top level: parses "rgb:" color replies and classifies the background luma.
// An input byte transfers every cycle while the queue has room.
// The result of a reply passes through the queue and the rescale pipeline stages
// (product, select, weighting, sum and compare) before out_valid rises.
// One byte and one result per cycle when not stalled; the queue absorbs output stalls.
// Reset (arst_n low) returns the parser to prefix search and empties queue and pipeline.
`default_nettype none
module osc_rgb_reply_luma_classifier
	import orlc_pkg::*;
#(
	parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF,
	parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] reply_byte,
	input  wire logic       end_of_reply,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      outcome,
	output logic [7:0]      red_level,
	output logic [7:0]      green_level,
	output logic [7:0]      blue_level
);

	localparam int ENTRY_W = 3 * ($clog2(MAX_HEX_DIGITS + 1) + 4 * MAX_HEX_DIGITS) + 1;

	logic               push, pop, full, empty;
	logic [ENTRY_W-1:0] push_entry, pop_entry;

	orlc_parser #(
		.MAX_HEX_DIGITS(MAX_HEX_DIGITS),
		.ENTRY_W       (ENTRY_W)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.reply_byte  (reply_byte),
		.end_of_reply(end_of_reply),
		.queue_full  (full),
		.push        (push),
		.push_entry  (push_entry)
	);

	orlc_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_entry),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_entry),
		.empty    (empty)
	);

	orlc_scaler #(
		.MAX_HEX_DIGITS(MAX_HEX_DIGITS),
		.ENTRY_W       (ENTRY_W)
	) u_scaler (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (empty),
		.q_data     (pop_entry),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.outcome    (outcome),
		.red_level  (red_level),
		.green_level(green_level),
		.blue_level (blue_level)
	);

endmodule
`default_nettype wire
